// ----- hdl/tga_rle_pixel_decoder_defines.svh -----
// Assertion macros shared by the TGA RLE pixel decoder modules.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TGARLE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tgarle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TGARLE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tgarle check failed");

`endif

// ----- hdl/tgarle_pkg.sv -----
// Types and constants of the TGA RLE pixel decoder.
package tgarle_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_BYTES_PER_PIXEL = 2'd0;
    localparam logic [1:0] REG_COMPRESSED_MODE = 2'd1;
    localparam logic [1:0] REG_ROW_WIDTH       = 2'd2;

    // Packet header fields
    localparam logic [7:0] RUN_FLAG = 8'h80;
    localparam logic [7:0] LEN_MASK = 8'h7F;

    // RGB555 masks
    localparam logic [15:0] RG_MASK = 16'h7FE0;
    localparam logic [15:0] B_MASK  = 16'h001F;

    typedef struct packed {
        logic [2:0]  bytes_per_pixel;
        logic        compressed_mode;
        logic [15:0] row_width;
    } cfg_t;

    typedef struct packed {
        logic        emit;
        logic [31:0] pixel_value;
        logic [7:0]  repeat_count;
        logic        row_done;
    } result_t;

endpackage

// ----- hdl/tgarle_core.sv -----
// Decode state and per-byte update: header parse, pixel gather, row count.
`include "tga_rle_pixel_decoder_defines.svh"

module tgarle_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [7:0]         stream_byte,
    input  tgarle_pkg::cfg_t   cfg,
    output tgarle_pkg::result_t result
);
    import tgarle_pkg::*;

    logic        awaiting_header_reg, awaiting_header_next;
    logic        run_packet_reg,      run_packet_next;
    logic [7:0]  pixels_left_reg,     pixels_left_next;
    logic [7:0]  packet_length_reg,   packet_length_next;
    logic [1:0]  byte_index_reg,      byte_index_next;
    logic [31:0] pixel_shift_reg,     pixel_shift_next;
    logic [16:0] row_count_reg,       row_count_next;

    logic [2:0]  eff_size;
    logic [2:0]  got;
    logic        complete;
    logic [31:0] shift_or;
    logic [31:0] pixel;
    logic [7:0]  hdr_len;
    logic [16:0] row_inc;

    // Pixel size saturates to 1..4
    always_comb
    begin
        if (cfg.bytes_per_pixel == 3'd0)
            eff_size = 3'd1;
        else if (cfg.bytes_per_pixel > 3'd4)
            eff_size = 3'd4;
        else
            eff_size = cfg.bytes_per_pixel;
    end

    // Byte gather and RGB555 -> RGB565
    assign shift_or = pixel_shift_reg | (32'(stream_byte) << {byte_index_reg, 3'b000});
    assign got      = {1'b0, byte_index_reg} + 3'd1;
    assign complete = (got >= eff_size);
    always_comb
    begin
        if (eff_size == 3'd2)
            pixel = {16'h0000, ((shift_or[15:0] & RG_MASK) << 1) | (shift_or[15:0] & B_MASK)};
        else
            pixel = shift_or;
    end

    assign hdr_len = (stream_byte & LEN_MASK) + 8'd1;
    assign row_inc = row_count_reg + 17'd1;

    // Next state and result
    always_comb
    begin
        awaiting_header_next = awaiting_header_reg;
        run_packet_next      = run_packet_reg;
        pixels_left_next     = pixels_left_reg;
        packet_length_next   = packet_length_reg;
        byte_index_next      = byte_index_reg;
        pixel_shift_next     = pixel_shift_reg;
        row_count_next       = row_count_reg;
        result.emit          = 1'b0;
        result.pixel_value   = pixel;
        result.repeat_count  = 8'd1;
        result.row_done      = 1'b0;

        if (step)
        begin
            if (cfg.compressed_mode && awaiting_header_reg)
            begin
                // packet header
                packet_length_next   = hdr_len;
                run_packet_next      = (stream_byte & RUN_FLAG) != 8'h00;
                pixels_left_next     = ((stream_byte & RUN_FLAG) != 8'h00) ? 8'd1 : hdr_len;
                row_count_next       = row_count_reg + 17'(hdr_len);
                awaiting_header_next = 1'b0;
                byte_index_next      = 2'd0;
                pixel_shift_next     = 32'h0;
            end
            else if (!complete)
            begin
                byte_index_next  = got[1:0];
                pixel_shift_next = shift_or;
            end
            else
            begin
                byte_index_next  = 2'd0;
                pixel_shift_next = 32'h0;
                result.emit      = 1'b1;
                if (cfg.compressed_mode)
                begin
                    result.repeat_count = run_packet_reg ? packet_length_reg : 8'd1;
                    if (pixels_left_reg <= 8'd1)
                    begin
                        // packet boundary: row may end here
                        pixels_left_next     = 8'd0;
                        awaiting_header_next = 1'b1;
                        if (row_count_reg >= {1'b0, cfg.row_width})
                        begin
                            result.row_done = 1'b1;
                            row_count_next  = 17'd0;
                        end
                    end
                    else
                    begin
                        pixels_left_next = pixels_left_reg - 8'd1;
                    end
                end
                else
                begin
                    if (row_inc >= {1'b0, cfg.row_width})
                    begin
                        result.row_done = 1'b1;
                        row_count_next  = 17'd0;
                    end
                    else
                    begin
                        row_count_next = row_inc;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaiting_header_reg <= 1'b1;
            run_packet_reg      <= 1'b0;
            pixels_left_reg     <= 8'd0;
            packet_length_reg   <= 8'd0;
            byte_index_reg      <= 2'd0;
            pixel_shift_reg     <= 32'h0;
            row_count_reg       <= 17'd0;
        end
        else
        begin
            awaiting_header_reg <= awaiting_header_next;
            run_packet_reg      <= run_packet_next;
            pixels_left_reg     <= pixels_left_next;
            packet_length_reg   <= packet_length_next;
            byte_index_reg      <= byte_index_next;
            pixel_shift_reg     <= pixel_shift_next;
            row_count_reg       <= row_count_next;
        end
    end

    // Inside a packet at least one stored pixel is still due
    `TGARLE_ASSERT_IMP(a_pkt_pixels_due, !awaiting_header_reg, pixels_left_reg != 8'd0)
    // No gathered bytes when the byte index is back at zero
    `TGARLE_ASSERT_IMP(a_shift_clear, byte_index_reg == 2'd0, pixel_shift_reg == 32'h0)
    // Inside a packet its length is at least one
    `TGARLE_ASSERT_IMP(a_pkt_len_nonzero, !awaiting_header_reg, packet_length_reg != 8'd0)

endmodule

// ----- hdl/tga_rle_pixel_decoder.sv -----
// An accepted byte goes to the input register; its result goes to the result register on m_axis.
// Throughput: one byte per cycle unless m_axis stalls; the update is one pass, no iteration.
// Pixels leave at most one per byte: one per bytes_per_pixel bytes, headers give none.
// Reset (rst_n low, async): stages empty, packet state awaits a header, config returns
// to 1 byte per pixel, compressed mode, row width 1.
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_pixel_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] stream_byte
    // pixel stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    output logic        m_axis_tlast    // row_done
);
    import tgarle_pkg::*;

    cfg_t        cfg_reg, cfg_next;
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg, in_byte_next;
    logic        out_valid_reg, out_valid_next;
    logic [39:0] out_data_reg, out_data_next;
    logic        out_last_reg, out_last_next;
    logic        advance;
    result_t     res;

    // Configuration registers
    assign cfg_ready = 1'b1;
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BYTES_PER_PIXEL: cfg_next.bytes_per_pixel = cfg_data[2:0];
                REG_COMPRESSED_MODE: cfg_next.compressed_mode = cfg_data[0];
                REG_ROW_WIDTH:       cfg_next.row_width       = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    // Input stage moves on when the result slot is free or being drained
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
    assign in_byte_next  = s_axis_tready ? s_axis_tdata : in_byte_reg;

    tgarle_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .stream_byte (in_byte_reg),
        .cfg         (cfg_reg),
        .result      (res)
    );

    // Result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (advance)
        begin
            out_valid_next = res.emit;
            out_data_next  = {res.repeat_count, res.pixel_value};
            out_last_next  = res.row_done;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= '{bytes_per_pixel: 3'd1, compressed_mode: 1'b1, row_width: 16'd1};
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // A held byte is not dropped while the result slot is blocked
    `TGARLE_ASSERT_NXT(a_in_hold, in_valid_reg && !advance, in_valid_reg)
    // A pixel produced by the core lands in the result register
    `TGARLE_ASSERT_NXT(a_emit_lands, advance && res.emit, out_valid_reg)
    // Every delivered pixel carries a nonzero repeat
    `TGARLE_ASSERT_IMP(a_rep_nonzero, out_valid_reg, out_data_reg[39:32] != 8'd0)

endmodule
